// ===== rtl/core/layer_window_blend_compositor_unit_defines.svh =====
// assertion macros for the layer window blend compositor
// no dependencies; included by the top level only
`ifndef LAYER_WINDOW_BLEND_COMPOSITOR_UNIT_DEFINES_SVH
`define LAYER_WINDOW_BLEND_COMPOSITOR_UNIT_DEFINES_SVH

// same-cycle implication under async active-low reset
`define LWBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under async active-low reset
`define LWBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lwbc_pkg.sv =====
// shared types, codes and helper functions for the layer window blend compositor
// no dependencies
package lwbc_pkg;

	localparam int unsigned LINE_WIDTH = 240;
	localparam int unsigned XCMP_W = 11;

	typedef logic [2:0] layer_t;
	typedef logic [1:0] mode_t;
	typedef logic [2:0] reg_idx_t;

	localparam layer_t L_NONE = 3'd0;
	localparam layer_t L_BD   = 3'd1;
	localparam layer_t L_BG0  = 3'd2;
	localparam layer_t L_OBJ  = 3'd6;

	localparam mode_t MODE_PLAIN  = 2'd0;
	localparam mode_t MODE_ALPHA  = 2'd1;
	localparam mode_t MODE_BRIGHT = 2'd2;
	localparam mode_t MODE_DARK   = 2'd3;

	localparam reg_idx_t REG_WIN_EN    = 3'd0;
	localparam reg_idx_t REG_WIN0      = 3'd1;
	localparam reg_idx_t REG_WIN1      = 3'd2;
	localparam reg_idx_t REG_WIN_MASKS = 3'd3;
	localparam reg_idx_t REG_BLD_CTRL  = 3'd4;
	localparam reg_idx_t REG_BLD_WT    = 3'd5;
	localparam reg_idx_t REG_BG_PRIO   = 3'd6;
	localparam reg_idx_t REG_BACKDROP  = 3'd7;

	localparam int unsigned MASK_OBJ_BIT = 4;
	localparam int unsigned MASK_FX_BIT  = 5;

	// 5-bit channel to 8-bit
	function automatic logic [7:0] expand5(input logic [4:0] c);
		logic [14:0] p;
		p = 15'(c) * 15'd527 + 15'd23;
		return p[13:6];
	endfunction

	// first candidate in priority-then-index order; {found, index}
	function automatic logic [2:0] pick_first(input logic [3:0] cand, input logic [7:0] prio);
		logic [3:0] win;
		logic [1:0] pb;
		logic [1:0] pc;
		logic [2:0] r;
		win = '0;
		r = '0;
		for (int b = 0; b < 4; b++) begin
			win[b] = cand[b];
			pb = prio[2*b +: 2];
			for (int c = 0; c < 4; c++) begin
				pc = prio[2*c +: 2];
				if (c != b && cand[c] && (pc < pb || (pc == pb && c < b))) begin
					win[b] = 1'b0;
				end
			end
		end
		for (int b = 0; b < 4; b++) begin
			if (win[b]) begin
				r = {1'b1, 2'(b)};
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/layer_window_blend_compositor_unit.sv =====
// layer window blend compositor: window select, priority order and blend/fade per pixel
// depends on lwbc_pkg and layer_window_blend_compositor_unit_defines.svh
//
// channel  | handshake               | payload
// ---------+-------------------------+----------------------------------------------
// pixel in | start, busy             | pix_x, pix_y, bg0..bg3_pixel, obj_pixel
// result   | done (one-cycle strobe) | final_color
// config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// one pixel per clock; busy is never raised
// pipeline: input register, then blend/fade multiplies into the result register
// arst_n clears the configuration registers and the stage valids
// the result side cannot stall; done marks each result for one cycle
`include "layer_window_blend_compositor_unit_defines.svh"

module layer_window_blend_compositor_unit #(
	parameter int unsigned LINE_WIDTH = lwbc_pkg::LINE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  pix_x,
	input  logic [7:0]  pix_y,
	input  logic [24:0] bg0_pixel,
	input  logic [24:0] bg1_pixel,
	input  logic [24:0] bg2_pixel,
	input  logic [24:0] bg3_pixel,
	input  logic [31:0] obj_pixel,
	output logic        done,
	output logic [23:0] final_color,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [2:0]  window_enables_q;
	logic [31:0] win0_bounds_q;
	logic [31:0] win1_bounds_q;
	logic [31:0] window_layer_masks_q;
	logic [15:0] blend_control_q;
	logic [14:0] blend_weights_q;
	logic [7:0]  bg_priorities_q;
	logic [14:0] backdrop_color_q;

	logic        valid_s1;
	logic [7:0]  pix_x_s1;
	logic [7:0]  pix_y_s1;
	logic [24:0] bg_s1 [4];
	logic [31:0] obj_s1;

	logic        valid_s2;
	logic [23:0] color_s2;

	logic [7:0]  attr;
	logic [1:0]  objprio;
	logic [3:0]  opq;
	logic        win0_hit;
	logic        win1_hit;
	logic        beyond_line;
	logic [7:0]  mask;
	lwbc_pkg::mode_t mode;
	logic [23:0] bd_rgb;
	logic [4:0]  eva;
	logic [4:0]  evb;
	logic [4:0]  fade;
	logic [2:0]  plain_pick;
	logic [2:0]  top_pick;
	logic [2:0]  bot_pick;
	logic [2:0]  fade_pick;
	logic [3:0]  top_onehot;
	lwbc_pkg::layer_t plain_layer;
	lwbc_pkg::layer_t upper_tgt;
	lwbc_pkg::layer_t lower_tgt;
	lwbc_pkg::layer_t fade_layer;
	logic [1:0]  tp_bg;
	logic [1:0]  bp_bg;
	logic [2:0]  tp;
	logic [2:0]  bp;
	logic [7:0]  obj_key;
	logic [23:0] top_rgb;
	logic [23:0] bot_rgb;
	logic [23:0] fade_rgb;
	logic [23:0] alpha_rgb;
	logic [23:0] bright_rgb;
	logic [23:0] dark_rgb;
	logic [23:0] result;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done        = valid_s2;
	assign final_color = color_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_enables_q     <= '0;
			win0_bounds_q        <= '0;
			win1_bounds_q        <= '0;
			window_layer_masks_q <= '0;
			blend_control_q      <= '0;
			blend_weights_q      <= '0;
			bg_priorities_q      <= '0;
			backdrop_color_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lwbc_pkg::REG_WIN_EN:    window_enables_q     <= cfg_data[2:0];
				lwbc_pkg::REG_WIN0:      win0_bounds_q        <= cfg_data;
				lwbc_pkg::REG_WIN1:      win1_bounds_q        <= cfg_data;
				lwbc_pkg::REG_WIN_MASKS: window_layer_masks_q <= cfg_data;
				lwbc_pkg::REG_BLD_CTRL:  blend_control_q      <= cfg_data[15:0];
				lwbc_pkg::REG_BLD_WT:    blend_weights_q      <= cfg_data[14:0];
				lwbc_pkg::REG_BG_PRIO:   bg_priorities_q      <= cfg_data[7:0];
				lwbc_pkg::REG_BACKDROP:  backdrop_color_q     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pix_x_s1 <= pix_x;
			pix_y_s1 <= pix_y;
			bg_s1[0] <= bg0_pixel;
			bg_s1[1] <= bg1_pixel;
			bg_s1[2] <= bg2_pixel;
			bg_s1[3] <= bg3_pixel;
			obj_s1   <= obj_pixel;
		end
		if (valid_s1) begin
			color_s2 <= result;
		end
	end

	function automatic logic [23:0] layer_color(input lwbc_pkg::layer_t code,
		input logic [23:0] bd, input logic [31:0] obj, input logic [24:0] b0,
		input logic [24:0] b1, input logic [24:0] b2, input logic [24:0] b3);
		logic [23:0] c;
		unique case (code)
			lwbc_pkg::L_BD:      c = bd;
			lwbc_pkg::L_BG0:     c = b0[23:0];
			lwbc_pkg::L_BG0 + 1: c = b1[23:0];
			lwbc_pkg::L_BG0 + 2: c = b2[23:0];
			lwbc_pkg::L_BG0 + 3: c = b3[23:0];
			lwbc_pkg::L_OBJ:     c = obj[23:0];
			default:             c = '0;
		endcase
		return c;
	endfunction

	// window, order and target selection
	always_comb begin
		attr    = obj_s1[31:24];
		objprio = attr[2:1];
		for (int b = 0; b < 4; b++) begin
			opq[b] = bg_s1[b][24];
		end
		eva  = blend_weights_q[4:0];
		evb  = blend_weights_q[9:5];
		fade = blend_weights_q[14:10];
		bd_rgb = {lwbc_pkg::expand5(backdrop_color_q[14:10]),
			lwbc_pkg::expand5(backdrop_color_q[9:5]),
			lwbc_pkg::expand5(backdrop_color_q[4:0])};
		beyond_line = {3'b000, pix_x_s1} >=
			lwbc_pkg::XCMP_W'(LINE_WIDTH);

		win0_hit = pix_x_s1 >= win0_bounds_q[31:24] && pix_x_s1 < win0_bounds_q[23:16] &&
			pix_y_s1 >= win0_bounds_q[15:8] && pix_y_s1 < win0_bounds_q[7:0];
		win1_hit = pix_x_s1 >= win1_bounds_q[31:24] && pix_x_s1 < win1_bounds_q[23:16] &&
			pix_y_s1 >= win1_bounds_q[15:8] && pix_y_s1 < win1_bounds_q[7:0];

		if (window_enables_q == 3'b000) begin
			mask = 8'hFF;
		end else if (window_enables_q[0] && win0_hit) begin
			mask = window_layer_masks_q[7:0];
		end else if (window_enables_q[1] && win1_hit) begin
			mask = window_layer_masks_q[15:8];
		end else if (window_enables_q[2] && attr[6]) begin
			mask = window_layer_masks_q[31:24];
		end else begin
			mask = window_layer_masks_q[23:16];
		end

		mode = blend_control_q[7:6];
		if (!mask[lwbc_pkg::MASK_FX_BIT]) begin
			mode = lwbc_pkg::MODE_PLAIN;
		end
		if (attr[0]) begin
			mode = lwbc_pkg::MODE_ALPHA;
		end

		// plain priority select
		plain_pick = lwbc_pkg::pick_first(mask[3:0] & opq, bg_priorities_q);
		plain_layer = plain_pick[2] ? lwbc_pkg::L_BG0 + {1'b0, plain_pick[1:0]} :
			lwbc_pkg::L_BD;
		if (mask[lwbc_pkg::MASK_OBJ_BIT] && attr[7]) begin
			plain_layer = lwbc_pkg::L_OBJ;
		end

		// alpha targets
		top_pick = lwbc_pkg::pick_first(mask[3:0] & opq & blend_control_q[3:0],
			bg_priorities_q);
		top_onehot = top_pick[2] ? 4'(4'b0001 << top_pick[1:0]) : 4'b0000;
		bot_pick = lwbc_pkg::pick_first(mask[3:0] & opq & blend_control_q[11:8] & ~top_onehot,
			bg_priorities_q);
		upper_tgt = top_pick[2] ? lwbc_pkg::L_BG0 + {1'b0, top_pick[1:0]} :
			(blend_control_q[5] ? lwbc_pkg::L_BD : lwbc_pkg::L_NONE);
		lower_tgt = bot_pick[2] ? lwbc_pkg::L_BG0 + {1'b0, bot_pick[1:0]} :
			(blend_control_q[13] ? lwbc_pkg::L_BD : lwbc_pkg::L_NONE);
		tp_bg = bg_priorities_q[2*top_pick[1:0] +: 2];
		bp_bg = bg_priorities_q[2*bot_pick[1:0] +: 2];
		tp = top_pick[2] ? {1'b0, tp_bg} : 3'd4;
		bp = bot_pick[2] ? {1'b0, bp_bg} : 3'd4;
		obj_key = attr & 8'h81;
		if (mask[lwbc_pkg::MASK_OBJ_BIT]) begin
			if (obj_key == 8'h81 || (blend_control_q[4] && obj_key == 8'h80 &&
				{1'b0, objprio} <= tp)) begin
				lower_tgt = upper_tgt;
				upper_tgt = lwbc_pkg::L_OBJ;
			end else if (blend_control_q[12] && obj_key == 8'h80 &&
				{1'b0, objprio} <= bp) begin
				lower_tgt = lwbc_pkg::L_OBJ;
			end
		end

		// fade target
		fade_pick = lwbc_pkg::pick_first(mask[3:0] & opq & blend_control_q[11:8],
			bg_priorities_q);
		fade_layer = fade_pick[2] ? lwbc_pkg::L_BG0 + {1'b0, fade_pick[1:0]} :
			lwbc_pkg::L_NONE;
		if (mask[lwbc_pkg::MASK_OBJ_BIT] && blend_control_q[4] && attr[7]) begin
			fade_layer = lwbc_pkg::L_OBJ;
		end
	end

	// per-channel arithmetic and final select
	always_comb begin
		logic [7:0]  ct;
		logic [7:0]  cb;
		logic [7:0]  d;
		logic [13:0] asum;
		logic [12:0] pf;
		logic [12:0] pd;
		logic [9:0]  bsum;
		top_rgb  = layer_color(upper_tgt, bd_rgb, obj_s1, bg_s1[0], bg_s1[1], bg_s1[2],
			bg_s1[3]);
		bot_rgb  = layer_color(lower_tgt, bd_rgb, obj_s1, bg_s1[0], bg_s1[1], bg_s1[2],
			bg_s1[3]);
		fade_rgb = layer_color(fade_layer, bd_rgb, obj_s1, bg_s1[0], bg_s1[1], bg_s1[2],
			bg_s1[3]);
		for (int i = 0; i < 3; i++) begin
			ct = top_rgb[8*i +: 8];
			cb = bot_rgb[8*i +: 8];
			asum = 14'(13'(ct) * 13'(eva)) + 14'(13'(cb) * 13'(evb));
			alpha_rgb[8*i +: 8] = (asum[13:12] != 2'b00) ? 8'hFF : asum[11:4];

			d = fade_rgb[8*i +: 8];
			pf = 13'(8'hFF - d) * 13'(fade);
			bsum = 10'(d) + 10'(pf[12:4]);
			bright_rgb[8*i +: 8] = (bsum[9:8] != 2'b00) ? 8'hFF : bsum[7:0];

			pd = 13'(d) * 13'(fade);
			dark_rgb[8*i +: 8] = (pd[12:4] > {1'b0, d}) ? 8'h00 : d - pd[11:4];
		end

		if (beyond_line) begin
			result = bd_rgb;
		end else begin
			case (mode)
				lwbc_pkg::MODE_PLAIN: begin
					result = layer_color(plain_layer, bd_rgb, obj_s1, bg_s1[0], bg_s1[1],
						bg_s1[2], bg_s1[3]);
				end
				lwbc_pkg::MODE_ALPHA: begin
					if (upper_tgt != lwbc_pkg::L_NONE && lower_tgt != lwbc_pkg::L_NONE) begin
						result = alpha_rgb;
					end else if (upper_tgt != lwbc_pkg::L_NONE) begin
						result = top_rgb;
					end else if (lower_tgt != lwbc_pkg::L_NONE) begin
						result = bot_rgb;
					end else begin
						result = bd_rgb;
					end
				end
				lwbc_pkg::MODE_BRIGHT: begin
					result = (fade_layer == lwbc_pkg::L_NONE) ? 24'hFFFFFF : bright_rgb;
				end
				default: begin
					result = (fade_layer == lwbc_pkg::L_NONE) ? 24'h000000 : dark_rgb;
				end
			endcase
		end
	end

	`LWBC_ASSERT_NEXT(a_result_follows, clk, arst_n, valid_s1, done,
		"registered pixel produced no result")
	`LWBC_ASSERT_NEXT(a_no_stray_result, clk, arst_n, !valid_s1, !done,
		"result without a registered pixel")
	`LWBC_ASSERT_NEXT(a_beyond_line_backdrop, clk, arst_n, valid_s1 && beyond_line,
		final_color == $past(bd_rgb), "pixel past line end not backdrop")
	`LWBC_ASSERT_NOW(a_never_busy, clk, arst_n, start, !busy,
		"pixel beat refused while busy")

endmodule
